// ===== hw/rtl/lavb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_pkg
// Shared types and constants of the look-at view basis pipeline.
// ----------------------------------------------------------------------------
package lavb_pkg;

	localparam int COORD_W  = 32;            // Q16.16 coordinates
	localparam int UNIT_W   = 16;            // Q1.14 axis components
	localparam int FRAC_W   = 14;
	localparam int Q14_ONE  = 16384;
	localparam int VEC_W    = 48;            // signed vector entering a normalizer
	localparam int MAG_W    = VEC_W;
	localparam int SHIFT_W  = 6;             // bit index into a magnitude
	localparam int SC_W     = 31;            // scaled magnitude, top bit at 2^30
	localparam int SQ_W     = 2 * SC_W;
	localparam int SUM_W    = 64;
	localparam int ROOT_W   = 32;
	localparam int REM_W    = ROOT_W + 3;
	localparam int QUO_W    = 15;
	localparam int NUM_W    = SC_W + QUO_W + 1;
	localparam int DEN_W    = ROOT_W + 1;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef coord_t [2:0] coord3_t;
	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef unit_t [2:0] unit3_t;
	typedef logic signed [VEC_W-1:0] vec_t;
	typedef vec_t [2:0] vec3_t;

	typedef struct packed {
		logic                      action;
		logic signed [COORD_W-1:0] position_x;
		logic signed [COORD_W-1:0] position_y;
		logic signed [COORD_W-1:0] position_z;
		logic signed [COORD_W-1:0] aim_x;
		logic signed [COORD_W-1:0] aim_y;
		logic signed [COORD_W-1:0] aim_z;
		logic signed [COORD_W-1:0] up_ref_x;
		logic signed [COORD_W-1:0] up_ref_y;
		logic signed [COORD_W-1:0] up_ref_z;
	} pose_t;

	typedef struct packed {
		logic signed [UNIT_W-1:0]  right_x;
		logic signed [UNIT_W-1:0]  right_y;
		logic signed [UNIT_W-1:0]  right_z;
		logic signed [UNIT_W-1:0]  cam_up_x;
		logic signed [UNIT_W-1:0]  cam_up_y;
		logic signed [UNIT_W-1:0]  cam_up_z;
		logic signed [UNIT_W-1:0]  forward_x;
		logic signed [UNIT_W-1:0]  forward_y;
		logic signed [UNIT_W-1:0]  forward_z;
		logic signed [COORD_W-1:0] offset_right;
		logic signed [COORD_W-1:0] offset_up;
		logic signed [COORD_W-1:0] offset_forward;
	} basis_t;

	// Data that rides alongside a vector through a normalizer.
	typedef struct packed {
		coord3_t pos;
		coord3_t up;
		unit3_t  fwd;
		logic    ok;
	} side_t;

	// Axes handed to the back end.
	typedef struct packed {
		logic    ok;
		unit3_t  u;
		unit3_t  v;
		unit3_t  w;
		coord3_t p;
	} axes_t;

endpackage

// ===== hw/rtl/lavb_norm.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_norm
// Pipelined vector normalizer: block scaling, sum of squares, bit-serial
// square root and restoring division, one result bit per stage.
// ----------------------------------------------------------------------------
module lavb_norm import lavb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   vec_valid,
	input  vec3_t  vec,
	input  side_t  vec_side,
	output logic   unit_valid,
	output logic   unit_ok,
	output unit3_t unit,
	output side_t  unit_side
);

	localparam int EXT_W = MAG_W + SC_W - 1;

	typedef struct packed {
		logic                         nz;
		logic [2:0]                   neg;
		logic [2:0][SC_W-1:0]         sc;
		logic [REM_W-1:0]             rem;
		logic [ROOT_W-1:0]            root;
		logic [SUM_W-1:0]             rad;
		side_t                        side;
	} sq_t;

	typedef struct packed {
		logic                         nz;
		logic [2:0]                   neg;
		logic [2:0][NUM_W-1:0]        num;
		logic [DEN_W-1:0]             den;
		logic [2:0][QUO_W-1:0]        quo;
		side_t                        side;
	} dv_t;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [2:0]            neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [2:0][MAG_W-1:0] mag_s1, mag_s2, mag_s3;
	side_t                 side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [MAG_W-1:0]      max_s2;
	logic [MAG_W-1:0]      max01_c, max_c;
	logic [SHIFT_W-1:0]    msb_c, msb_s3;
	logic                  nz_s3, nz_s4, nz_s5;
	logic [EXT_W-1:0]      ext_c [3];
	logic [2:0][SC_W-1:0]  sc_c, sc_s4, sc_s5;
	logic [SQ_W-1:0]       sq_s5 [3];
	sq_t                   sq_s [ROOT_W+1];
	logic                  sq_vld [ROOT_W+1];
	dv_t                   dv_c;
	dv_t                   dv_s [QUO_W+1];
	logic                  dv_vld [QUO_W+1];
	logic [QUO_W-1:0]      q_c [3];
	unit3_t                unit_c;

	always_comb begin
		max01_c = (mag_s1[1] > mag_s1[0]) ? mag_s1[1] : mag_s1[0];
		max_c   = (mag_s1[2] > max01_c) ? mag_s1[2] : max01_c;
	end

	always_comb begin
		msb_c = '0;
		for (int b = 0; b < MAG_W; b++) begin
			if (max_s2[b]) msb_c = SHIFT_W'(b);
		end
	end

	// The largest magnitude lands with its top bit at 2^30; bits shifted
	// out at the bottom are dropped.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ext_c[i] = {mag_s3[i], {(SC_W-1){1'b0}}};
			sc_c[i]  = SC_W'(ext_c[i] >> msb_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			sq_vld[0] <= 1'b0;
		end else if (en) begin
			vld_s1    <= vec_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			sq_vld[0] <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= vec[i][VEC_W-1];
				mag_s1[i] <= vec[i][VEC_W-1] ? -vec[i] : vec[i];
			end
			side_s1 <= vec_side;

			mag_s2  <= mag_s1;
			neg_s2  <= neg_s1;
			max_s2  <= max_c;
			side_s2 <= side_s1;

			mag_s3  <= mag_s2;
			neg_s3  <= neg_s2;
			msb_s3  <= msb_c;
			nz_s3   <= |max_s2;
			side_s3 <= side_s2;

			sc_s4   <= sc_c;
			neg_s4  <= neg_s3;
			nz_s4   <= nz_s3;
			side_s4 <= side_s3;

			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= SQ_W'(sc_s4[i]) * SQ_W'(sc_s4[i]);
			end
			sc_s5   <= sc_s4;
			neg_s5  <= neg_s4;
			nz_s5   <= nz_s4;
			side_s5 <= side_s4;

			sq_s[0].nz   <= nz_s5;
			sq_s[0].neg  <= neg_s5;
			sq_s[0].sc   <= sc_s5;
			sq_s[0].rem  <= '0;
			sq_s[0].root <= '0;
			sq_s[0].rad  <= SUM_W'(sq_s5[0]) + SUM_W'(sq_s5[1]) + SUM_W'(sq_s5[2]);
			sq_s[0].side <= side_s5;
		end
	end

	// Integer square root, two radicand bits and one root bit per stage.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		sq_t              cur;
		sq_t              nxt;
		logic [REM_W-1:0] rem_sh;
		logic [REM_W-1:0] trial;

		always_comb begin
			cur    = sq_s[k];
			nxt    = cur;
			rem_sh = {cur.rem[REM_W-3:0], cur.rad[SUM_W-1 -: 2]};
			trial  = {1'b0, cur.root, 2'b01};
			nxt.rad = cur.rad << 2;
			if (rem_sh >= trial) begin
				nxt.rem  = rem_sh - trial;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b1};
			end else begin
				nxt.rem  = rem_sh;
				nxt.root = {cur.root[ROOT_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) sq_s[k+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld[k+1] <= sq_vld[k];
			end
		end
	end

	// Each quotient is (2*m*2^14 + L) / (2*L), rounded to nearest.
	always_comb begin
		dv_c.nz   = sq_s[ROOT_W].nz;
		dv_c.neg  = sq_s[ROOT_W].neg;
		dv_c.side = sq_s[ROOT_W].side;
		dv_c.den  = {sq_s[ROOT_W].root, 1'b0};
		for (int i = 0; i < 3; i++) begin
			dv_c.num[i] = NUM_W'({sq_s[ROOT_W].sc[i], {QUO_W{1'b0}}})
				+ NUM_W'(sq_s[ROOT_W].root);
			dv_c.quo[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) dv_s[0] <= dv_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld[0] <= 1'b0;
		end else if (en) begin
			dv_vld[0] <= sq_vld[ROOT_W];
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		localparam int B = QUO_W - 1 - k;
		dv_t              cur;
		dv_t              nxt;
		logic [NUM_W-1:0] sub;

		always_comb begin
			cur = dv_s[k];
			nxt = cur;
			sub = NUM_W'(cur.den) << B;
			for (int i = 0; i < 3; i++) begin
				if (cur.num[i] >= sub) begin
					nxt.num[i]    = cur.num[i] - sub;
					nxt.quo[i][B] = 1'b1;
				end
			end
		end

		always_ff @(posedge clk) begin
			if (en) dv_s[k+1] <= nxt;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld[k+1] <= dv_vld[k];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			q_c[i] = dv_s[QUO_W].quo[i];
			if (q_c[i] > QUO_W'(Q14_ONE)) q_c[i] = QUO_W'(Q14_ONE);
			unit_c[i] = dv_s[QUO_W].neg[i] ? -UNIT_W'(q_c[i]) : UNIT_W'(q_c[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_valid <= 1'b0;
		end else if (en) begin
			unit_valid <= dv_vld[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			unit_ok   <= dv_s[QUO_W].nz;
			unit      <= unit_c;
			unit_side <= dv_s[QUO_W].side;
		end
	end

endmodule

// ===== hw/rtl/lavb_basis.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_basis
// Back end: camera up as forward cross right, then the three negated,
// rounded and saturated dot products with the position.
// ----------------------------------------------------------------------------
module lavb_basis import lavb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   en,
	input  logic   axes_valid,
	input  axes_t  axes,
	output logic   res_valid,
	output basis_t res
);

	localparam int VP_W   = 2 * UNIT_W;
	localparam int VD_W   = VP_W + 1;
	localparam int VQ_W   = VD_W + 1 - FRAC_W;
	localparam int DP_W   = UNIT_W + COORD_W;
	localparam int DOT_W  = DP_W + 2;
	localparam int DQ_W   = DOT_W + 1 - FRAC_W;
	localparam int HALF   = 1 << (FRAC_W - 1);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	axes_t car_s1, car_s2, car_s3, car_s4, car_s5, car_s6, car_s7, car_s8;
	axes_t car_c;

	logic signed [UNIT_W-1:0]  w_c [3];
	logic signed [UNIT_W-1:0]  u_c [3];
	logic signed [VP_W-1:0]    vp_s1 [6];
	logic signed [VD_W-1:0]    vd_s2 [3];
	logic [2:0]                vneg_s3;
	logic [VD_W-1:0]           vmag_s3 [3];
	logic [VD_W:0]             vrs_c [3];
	logic [VQ_W-1:0]           vq_c [3];
	unit3_t                    v_c;
	logic signed [UNIT_W-1:0]  ax_c [3][3];
	logic signed [COORD_W-1:0] p_c [3];
	logic signed [DP_W-1:0]    dp_s5 [3][3];
	logic signed [DOT_W-1:0]   dot_s6 [3];
	logic [2:0]                rneg_s7, rneg_s8;
	logic [DOT_W-1:0]          mag_s7 [3];
	logic [DOT_W:0]            drs_c [3];
	logic [DQ_W-1:0]           dq_c [3];
	logic [DQ_W-1:0]           lim_c [3];
	logic [COORD_W-1:0]        qs_c [3];
	logic [COORD_W-1:0]        qs_s8 [3];
	coord_t                    ofs_c [3];
	basis_t                    res_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[i] = $signed(axes.w[i]);
			u_c[i] = $signed(axes.u[i]);
		end
	end

	// Camera up, rounded half away from zero and clamped to one.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			vrs_c[i] = {1'b0, vmag_s3[i]} + (VD_W+1)'(HALF);
			vq_c[i]  = vrs_c[i][VD_W:FRAC_W];
			if (vq_c[i] > VQ_W'(Q14_ONE)) vq_c[i] = VQ_W'(Q14_ONE);
			v_c[i] = vneg_s3[i] ? -UNIT_W'(vq_c[i]) : UNIT_W'(vq_c[i]);
		end
		car_c   = car_s3;
		car_c.v = v_c;
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			ax_c[0][i] = $signed(car_s4.u[i]);
			ax_c[1][i] = $signed(car_s4.v[i]);
			ax_c[2][i] = $signed(car_s4.w[i]);
			p_c[i]     = $signed(car_s4.p[i]);
		end
	end

	// The rounded magnitude is limited to 2^31 for a negative offset and
	// to 2^31 - 1 for a positive one.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			drs_c[a] = {1'b0, mag_s7[a]} + (DOT_W+1)'(HALF);
			dq_c[a]  = drs_c[a][DOT_W:FRAC_W];
			lim_c[a] = rneg_s7[a] ? DQ_W'(33'h0_8000_0000) : DQ_W'(33'h0_7FFF_FFFF);
			qs_c[a]  = (dq_c[a] > lim_c[a]) ? COORD_W'(lim_c[a]) : COORD_W'(dq_c[a]);
		end
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			ofs_c[a] = rneg_s8[a] ? -qs_s8[a] : qs_s8[a];
		end
		res_c.right_x        = car_s8.u[0];
		res_c.right_y        = car_s8.u[1];
		res_c.right_z        = car_s8.u[2];
		res_c.cam_up_x       = car_s8.v[0];
		res_c.cam_up_y       = car_s8.v[1];
		res_c.cam_up_z       = car_s8.v[2];
		res_c.forward_x      = car_s8.w[0];
		res_c.forward_y      = car_s8.w[1];
		res_c.forward_z      = car_s8.w[2];
		res_c.offset_right   = ofs_c[0];
		res_c.offset_up      = ofs_c[1];
		res_c.offset_forward = ofs_c[2];
		// A zero view direction or an up reference parallel to it gives all zeros.
		if (!car_s8.ok) res_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			vld_s5    <= 1'b0;
			vld_s6    <= 1'b0;
			vld_s7    <= 1'b0;
			vld_s8    <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			vld_s1    <= axes_valid;
			vld_s2    <= vld_s1;
			vld_s3    <= vld_s2;
			vld_s4    <= vld_s3;
			vld_s5    <= vld_s4;
			vld_s6    <= vld_s5;
			vld_s7    <= vld_s6;
			vld_s8    <= vld_s7;
			res_valid <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vp_s1[0] <= w_c[1] * u_c[2];
			vp_s1[1] <= w_c[2] * u_c[1];
			vp_s1[2] <= w_c[2] * u_c[0];
			vp_s1[3] <= w_c[0] * u_c[2];
			vp_s1[4] <= w_c[0] * u_c[1];
			vp_s1[5] <= w_c[1] * u_c[0];
			car_s1   <= axes;

			for (int i = 0; i < 3; i++) begin
				vd_s2[i] <= vp_s1[2*i] - vp_s1[2*i+1];
			end
			car_s2 <= car_s1;

			for (int i = 0; i < 3; i++) begin
				vneg_s3[i] <= vd_s2[i][VD_W-1];
				vmag_s3[i] <= vd_s2[i][VD_W-1] ? -vd_s2[i] : vd_s2[i];
			end
			car_s3 <= car_s2;

			car_s4 <= car_c;

			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					dp_s5[a][i] <= ax_c[a][i] * p_c[i];
				end
			end
			car_s5 <= car_s4;

			for (int a = 0; a < 3; a++) begin
				dot_s6[a] <= DOT_W'(dp_s5[a][0]) + DOT_W'(dp_s5[a][1])
					+ DOT_W'(dp_s5[a][2]);
			end
			car_s6 <= car_s5;

			// The offset is the negated dot, so it is negative when the dot
			// is positive.
			for (int a = 0; a < 3; a++) begin
				rneg_s7[a] <= !dot_s6[a][DOT_W-1] && (|dot_s6[a]);
				mag_s7[a]  <= dot_s6[a][DOT_W-1] ? -dot_s6[a] : dot_s6[a];
			end
			car_s7 <= car_s6;

			qs_s8   <= qs_c;
			rneg_s8 <= rneg_s7;
			car_s8  <= car_s7;

			res <= res_c;
		end
	end

endmodule

// ===== hw/rtl/look_at_view_basis_top.sv =====
`timescale 1ns / 1ps
// Throughput: one pose per cycle while pose_stall is low; every stage advances
// together, and the longest stage is one bit of the square root or of the division.
// A stalled output parks one result in a skid register before the pipeline holds.
// Reset clears the valid bits of all stages and both output registers.
// ----------------------------------------------------------------------------
// look_at_view_basis_top
// Look-at camera basis: forward, right and up axes in Q1.14 and the
// translation offsets in Q16.16, fully pipelined.
// ----------------------------------------------------------------------------
module look_at_view_basis_top import lavb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pose_valid,
	output logic   pose_stall,
	input  pose_t  pose,
	output logic   basis_valid,
	input  logic   basis_stall,
	output basis_t basis
);

	localparam int CP_W = UNIT_W + COORD_W;

	logic      en;
	logic      vld_s1, vld_s2, vld_s3, vld_s4;
	pose_t     pose_s1;
	vec3_t     d_c, d_s2;
	side_t     side_c, side_s2, side_s3, side_s4;
	side_t     xs_c;
	coord_t    aim_c [3];
	coord_t    pos_c [3];
	logic signed [COORD_W:0] df_c [3];
	coord_t    dsat_c [3];
	logic      n1_valid, n1_ok, n2_valid, n2_ok;
	unit3_t    n1_unit, n2_unit;
	side_t     n1_side, n2_side;
	logic signed [UNIT_W-1:0]  w_c [3];
	logic signed [COORD_W-1:0] up_c [3];
	logic signed [CP_W-1:0]    xp_s3 [6];
	vec3_t     c_s4;
	axes_t     axes_c;
	logic      res_valid;
	basis_t    res;
	logic      skid_vld_q;
	basis_t    skid_q;

	assign en         = !skid_vld_q;
	assign pose_stall = skid_vld_q;

	// Direction: with action set, aim minus position, saturated; else the aim.
	always_comb begin
		aim_c[0] = pose_s1.aim_x;
		aim_c[1] = pose_s1.aim_y;
		aim_c[2] = pose_s1.aim_z;
		pos_c[0] = pose_s1.position_x;
		pos_c[1] = pose_s1.position_y;
		pos_c[2] = pose_s1.position_z;
		for (int i = 0; i < 3; i++) begin
			df_c[i] = {aim_c[i][COORD_W-1], aim_c[i]} - {pos_c[i][COORD_W-1], pos_c[i]};
			if (df_c[i][COORD_W] != df_c[i][COORD_W-1]) begin
				dsat_c[i] = df_c[i][COORD_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				dsat_c[i] = df_c[i][COORD_W-1:0];
			end
			d_c[i] = pose_s1.action ? VEC_W'(dsat_c[i]) : VEC_W'(aim_c[i]);
		end
		side_c.pos = {pose_s1.position_z, pose_s1.position_y, pose_s1.position_x};
		side_c.up  = {pose_s1.up_ref_z, pose_s1.up_ref_y, pose_s1.up_ref_x};
		side_c.fwd = '0;
		side_c.ok  = 1'b0;
	end

	lavb_norm u_fwd_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vec_valid  (vld_s2),
		.vec        (d_s2),
		.vec_side   (side_s2),
		.unit_valid (n1_valid),
		.unit_ok    (n1_ok),
		.unit       (n1_unit),
		.unit_side  (n1_side)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_c[i]  = $signed(n1_unit[i]);
			up_c[i] = $signed(n1_side.up[i]);
		end
		xs_c     = n1_side;
		xs_c.fwd = n1_unit;
		xs_c.ok  = n1_ok;
	end

	lavb_norm u_right_norm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vec_valid  (vld_s4),
		.vec        (c_s4),
		.vec_side   (side_s4),
		.unit_valid (n2_valid),
		.unit_ok    (n2_ok),
		.unit       (n2_unit),
		.unit_side  (n2_side)
	);

	always_comb begin
		axes_c.ok = n2_ok && n2_side.ok;
		axes_c.u  = n2_unit;
		axes_c.v  = '0;
		axes_c.w  = n2_side.fwd;
		axes_c.p  = n2_side.pos;
	end

	lavb_basis u_basis (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.axes_valid (n2_valid),
		.axes       (axes_c),
		.res_valid  (res_valid),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= pose_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= n1_valid;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pose_s1 <= pose;

			d_s2    <= d_c;
			side_s2 <= side_c;

			// Forward cross up reference, formed exactly.
			xp_s3[0]    <= w_c[1] * up_c[2];
			xp_s3[1]    <= w_c[2] * up_c[1];
			xp_s3[2]    <= w_c[2] * up_c[0];
			xp_s3[3]    <= w_c[0] * up_c[2];
			xp_s3[4]    <= w_c[0] * up_c[1];
			xp_s3[5]    <= w_c[1] * up_c[0];
			side_s3     <= xs_c;

			for (int i = 0; i < 3; i++) begin
				c_s4[i] <= VEC_W'(xp_s3[2*i]) - VEC_W'(xp_s3[2*i+1]);
			end
			side_s4 <= side_s3;
		end
	end

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			basis_valid <= 1'b0;
			skid_vld_q  <= 1'b0;
		end else if (skid_vld_q) begin
			if (!basis_stall) skid_vld_q <= 1'b0;
		end else if (basis_valid && basis_stall) begin
			skid_vld_q <= res_valid;
		end else begin
			basis_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (!basis_stall) basis <= skid_q;
		end else if (basis_valid && basis_stall) begin
			skid_q <= res;
		end else begin
			basis <= res;
		end
	end

endmodule

// ===== sim/lavb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lavb_checker
// Watches the pose and basis channels, computes the expected camera basis of
// every pose transfer and compares each basis transfer with the oldest one.
// ----------------------------------------------------------------------------
module lavb_checker import lavb_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   pose_valid,
	input  logic   pose_stall,
	input  pose_t  pose,
	input  logic   basis_valid,
	input  logic   basis_stall,
	input  basis_t basis,
	output int     fail_count,
	output int     pending,
	output int     zero_count,
	output int     basis_count
);

	basis_t expected_bases[$];

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint round_off(longint v, int sh);
		longint unsigned mg;
		longint unsigned q;
		mg = (v < 0) ? longint'(-v) : longint'(v);
		q = (mg + (64'd1 << (sh - 1))) >> sh;
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned s);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b = b >> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Returns 0 for the zero vector.
	function automatic bit unit_vec(input longint v[3], output longint o[3]);
		longint unsigned mg[3];
		longint unsigned m;
		longint unsigned s;
		longint unsigned len;
		longint unsigned q;
		m = 0;
		s = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
			if (mg[i] > m) m = mg[i];
			o[i] = 0;
		end
		if (m == 0) return 0;
		while (m >= (64'd1 << 31)) begin
			for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
			m = m >> 1;
		end
		while (m < (64'd1 << 30)) begin
			for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
			m = m << 1;
		end
		for (int i = 0; i < 3; i++) s = s + mg[i] * mg[i];
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = ((mg[i] << 15) + len) / (2 * len);
			if (q > Q14_ONE) q = Q14_ONE;
			o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	function automatic longint neg_dot(longint a[3], longint p[3]);
		return sat32(round_off(-(a[0] * p[0] + a[1] * p[1] + a[2] * p[2]), 14));
	endfunction

	function automatic basis_t view_basis(pose_t t);
		longint p[3], a[3], up[3], d[3], c[3], w[3], u[3], v[3];
		basis_t b;
		b = '0;
		p = '{longint'(t.position_x), longint'(t.position_y), longint'(t.position_z)};
		a = '{longint'(t.aim_x), longint'(t.aim_y), longint'(t.aim_z)};
		up = '{longint'(t.up_ref_x), longint'(t.up_ref_y), longint'(t.up_ref_z)};
		for (int i = 0; i < 3; i++) d[i] = t.action ? sat32(a[i] - p[i]) : a[i];
		if (!unit_vec(d, w)) return b;
		c[0] = w[1] * up[2] - w[2] * up[1];
		c[1] = w[2] * up[0] - w[0] * up[2];
		c[2] = w[0] * up[1] - w[1] * up[0];
		if (!unit_vec(c, u)) return b;
		v[0] = w[1] * u[2] - w[2] * u[1];
		v[1] = w[2] * u[0] - w[0] * u[2];
		v[2] = w[0] * u[1] - w[1] * u[0];
		for (int i = 0; i < 3; i++) begin
			v[i] = round_off(v[i], 14);
			if (v[i] > Q14_ONE) v[i] = Q14_ONE;
			if (v[i] < -Q14_ONE) v[i] = -Q14_ONE;
		end
		b.right_x = UNIT_W'(u[0]); b.right_y = UNIT_W'(u[1]); b.right_z = UNIT_W'(u[2]);
		b.cam_up_x = UNIT_W'(v[0]); b.cam_up_y = UNIT_W'(v[1]);
		b.cam_up_z = UNIT_W'(v[2]);
		b.forward_x = UNIT_W'(w[0]); b.forward_y = UNIT_W'(w[1]);
		b.forward_z = UNIT_W'(w[2]);
		b.offset_right = COORD_W'(neg_dot(u, p));
		b.offset_up = COORD_W'(neg_dot(v, p));
		b.offset_forward = COORD_W'(neg_dot(w, p));
		return b;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		basis_t want;
		if (!arst_n) begin
			fail_count <= 0;
			zero_count <= 0;
			basis_count <= 0;
		end else begin
			if (pose_valid && !pose_stall) begin
				want = view_basis(pose);
				if (want == '0) zero_count <= zero_count + 1;
				expected_bases.push_back(want);
			end
			if (basis_valid && !basis_stall) begin
				basis_count <= basis_count + 1;
				if (expected_bases.size() == 0) begin
					if (fail_count < 10) $display("basis transfer with no pose pending: %h", basis);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_bases.pop_front();
					if (want !== basis) begin
						if (fail_count < 10) begin
							$display("basis mismatch at %0t", $realtime);
							$display("  expected %h", want);
							$display("  actual   %h", basis);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

	assign pending = expected_bases.size();

endmodule

// ===== sim/tb_look_at_view_basis_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_look_at_view_basis_top
// Drives directed and random camera poses into the look-at basis pipeline
// under varying idle patterns and a long output hold-off; the checker
// predicts and compares every basis.
// ----------------------------------------------------------------------------
module tb_look_at_view_basis_top;
	import lavb_pkg::*;

	localparam int LATENCY = 124;
	localparam int WATCHDOG = 20000;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   pose_valid = 1'b0;
	logic   pose_stall;
	pose_t  pose = '0;
	logic   basis_valid;
	logic   basis_stall = 1'b0;
	basis_t basis;
	int     fail_count, pending, zero_count, basis_count;
	int     send_idle = 32;
	int     recv_idle = 50;
	bit     hold_off = 1'b0;
	int     idle_cycles = 0;
	int     pose_count = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	look_at_view_basis_top u_top (
		.clk(clk), .arst_n(arst_n), .pose_valid(pose_valid), .pose_stall(pose_stall),
		.pose(pose), .basis_valid(basis_valid), .basis_stall(basis_stall), .basis(basis)
	);

	lavb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .pose_valid(pose_valid), .pose_stall(pose_stall),
		.pose(pose), .basis_valid(basis_valid), .basis_stall(basis_stall), .basis(basis),
		.fail_count(fail_count), .pending(pending), .zero_count(zero_count),
		.basis_count(basis_count)
	);

	// Receiver stall, one assignment per falling edge.
	always @(negedge clk) begin
		if (hold_off) basis_stall <= 1'b1;
		else basis_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if ((pose_valid && !pose_stall) || (basis_valid && !basis_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic logic [31:0] pick_coord(int mode);
		case (mode)
		0: return $urandom();
		1: return $urandom_range(2) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
		2: return $urandom_range(8) - 4;
		default: return $signed($urandom_range(65536 * 200)) - 65536 * 100;
		endcase
	endfunction

	// Offer one pose and hold it until the block takes it. Valid stays high
	// after the transfer until the next offer or the drain replaces it.
	task automatic offer_pose(pose_t t);
		while ($urandom_range(99) < send_idle) begin
			pose_valid <= 1'b0;
			@(negedge clk);
		end
		pose_valid <= 1'b1;
		pose <= t;
		@(posedge clk);
		while (pose_stall) @(posedge clk);
		pose_count++;
		@(negedge clk);
	endtask

	task automatic random_pose();
		pose_t t;
		int m;
		m = $urandom_range(9);
		t.action = 1'($urandom());
		t.position_x = pick_coord(m % 4); t.position_y = pick_coord(m % 4);
		t.position_z = pick_coord(m % 4);
		t.aim_x = pick_coord((m + 1) % 4); t.aim_y = pick_coord((m + 1) % 4);
		t.aim_z = pick_coord((m + 1) % 4);
		t.up_ref_x = pick_coord(m % 3 + 1); t.up_ref_y = pick_coord(m % 3 + 1);
		t.up_ref_z = pick_coord(m % 3 + 1);
		// Aim parallel to the up reference.
		if (m == 9) begin
			t.action = 1'b0;
			t.up_ref_x = t.aim_x; t.up_ref_y = t.aim_y; t.up_ref_z = t.aim_z;
		end
		offer_pose(t);
	endtask

	task automatic drain();
		pose_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
	endtask

	initial begin
		pose_t t;
		int hold;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		t = '0; offer_pose(t);                      // zero aim
		t.action = 1'b1; t.position_x = 32'h0001_0000; t.aim_x = 32'h0001_0000;
		offer_pose(t);                              // target equals position
		t = '0; t.aim_z = -32'sd65536; t.up_ref_y = 32'sd65536; offer_pose(t);
		t.up_ref_y = 0; t.up_ref_z = 32'sd65536; offer_pose(t); // parallel up
		t = '0; t.aim_x = 32'h7fff_ffff; t.aim_y = 32'h8000_0000; t.aim_z = 32'h7fff_ffff;
		t.up_ref_x = 32'h8000_0000; t.up_ref_y = 32'h8000_0000; t.up_ref_z = 32'h7fff_ffff;
		t.position_x = 32'h7fff_ffff; t.position_y = 32'h8000_0000;
		t.position_z = 32'h7fff_ffff;
		offer_pose(t);
		t.action = 1'b1; offer_pose(t);             // target equals position
		t.position_x = 32'h8000_0000; t.aim_x = 32'h7fff_ffff; offer_pose(t);
		t = '0; t.aim_y = 1; t.up_ref_x = 1; offer_pose(t); // tiny vectors
		t.position_x = 32'h7fff_ffff; t.position_y = 32'h7fff_ffff; offer_pose(t);
		t = '1; offer_pose(t);
		repeat (10) random_pose();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle = (phase == 0) ? 32 : (phase == 1) ? 50 : 0;
			recv_idle = (phase == 0) ? 50 : (phase == 1) ? 32 : 0;
			for (int k = 0; k < 540; k++) begin
				if (phase == 2 && k == 100) begin
					fork
						begin
							hold = 0;
							hold_off = 1'b1;
							while (hold < 400) begin
								@(negedge clk);
								hold++;
							end
							hold_off = 1'b0;
						end
					join_none
				end
				random_pose();
			end
		end
		drain();
		$display("Covered %0d poses over three idle patterns and a long output hold-off;",
			pose_count);
		$display("%0d bases checked, %0d of them degenerate.", basis_count, zero_count);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
